[hdl/adv_record_phy_flag_parser_top_defines.svh]
// Assertion helpers for the advertising PHY record parser.
`ifndef ADV_RECORD_PHY_FLAG_PARSER_TOP_DEFINES_SVH
`define ADV_RECORD_PHY_FLAG_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARPFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/arpfp_pkg.sv]
`default_nettype none

package arpfp_pkg;

	// Record type that carries the PHY flag bytes
	localparam logic [7:0] PhyRecordType = 8'h27;

	// Bit positions inside the tx and rx flag bytes
	localparam int unsigned Flag1mBit      = 0;
	localparam int unsigned Flag2mBit      = 1;
	localparam int unsigned FlagCodedS2Bit = 2;
	localparam int unsigned FlagCodedS8Bit = 3;

	// Width of the flag bits kept from the payload
	localparam int unsigned PendingW = 4;

	// Walk phase, one-hot
	typedef enum logic [3:0] {
		PH_LENGTH  = 4'b0001,
		PH_TYPE    = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_STOPPED = 4'b1000
	} phase_t;

	// Summary of one buffer; found sits in the lowest bit
	typedef struct packed {
		logic coded_s8;
		logic coded;
		logic phy_2m;
		logic phy_1m;
		logic found;
	} phy_flags_t;

endpackage

`default_nettype wire

[hdl/adv_record_phy_flag_parser_top.sv]
// Advertising-data PHY record parser. Feed the bytes of one advertising
// buffer on the slave stream, one per request, with tlast on the final
// byte. The block walks length-type-value records and, for every complete
// record of type 0x27 with at least two payload bytes, ORs the tx and rx
// flag bytes into sticky 1M, 2M, coded and coded-S8 flags. On the final
// byte it sends one result on the master stream and clears for the next
// buffer; other bytes send nothing. The block takes one byte per clock
// cycle while s_tready is high: each byte is registered, the walker
// state updates, and the result register loads as the final byte leaves
// the input register. A result that waits on the master side stalls input
// only once the next final byte reaches the walker.
`default_nettype none

module adv_record_phy_flag_parser_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] data_byte
	input  wire        s_tlast,   // is_last
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata    // [0] found_phy_record, [1] phy_1m, [2] phy_2m,
	                              // [3] phy_coded, [4] phy_coded_s8, [7:5] zero
);
	import arpfp_pkg::*;

`include "adv_record_phy_flag_parser_top_defines.svh"

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	logic       m_valid_q;
	phy_flags_t m_flags_q;
	phy_flags_t flags;

	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	arpfp_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.data_byte (data_s1),
		.is_last   (last_s1),
		.flags     (flags)
	);

	// Result register: load on the final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_flags_q <= flags;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_flags_q};

	`ARPFP_ASSERT_NOW(a_phy_implies_found, m_tvalid && (m_tdata[4:1] != 4'd0), m_tdata[0], "PHY flag without found record")
	`ARPFP_ASSERT_NOW(a_s8_implies_coded, m_tvalid && m_tdata[4], m_tdata[3], "coded S8 without coded")
	`ARPFP_ASSERT_NOW(a_stall_on_blocked_last, valid_s1 && last_s1 && m_valid_q && !m_tready, !s_tready, "input taken while final byte is blocked")
	`ARPFP_ASSERT_NEXT(a_result_follows_last, advance && last_s1, m_valid_q, "final byte gave no result")

endmodule

`default_nettype wire

[hdl/arpfp_walker.sv]
`default_nettype none

module arpfp_walker (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     step_en,
	input  wire [7:0]               data_byte,
	input  wire                     is_last,
	output arpfp_pkg::phy_flags_t   flags
);
	import arpfp_pkg::*;

	phase_t                phase_q,   phase_d;
	logic [7:0]            left_q,    left_d;
	logic [1:0]            index_q,   index_d;
	logic                  is_phy_q,  is_phy_d;
	logic [PendingW-1:0]   pend_q,    pend_d;
	logic                  pvalid_q,  pvalid_d;
	phy_flags_t            commit_q,  commit_d;
	logic                  finish;
	logic [7:0]            left_dec;

	assign left_dec = left_q - 8'd1;

	// Advance the record walk by one byte
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		index_d  = index_q;
		is_phy_d = is_phy_q;
		pend_d   = pend_q;
		pvalid_d = pvalid_q;
		finish   = 1'b0;
		unique case (phase_q)
			PH_LENGTH: begin
				if (data_byte == 8'd0) begin
					phase_d = PH_STOPPED;
				end else begin
					left_d  = data_byte;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				is_phy_d = (data_byte == PhyRecordType);
				index_d  = 2'd0;
				pend_d   = '0;
				pvalid_d = 1'b0;
				left_d   = left_dec;
				if (left_dec == 8'd0) begin
					finish = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (index_q == 2'd0) begin
					pend_d = data_byte[PendingW-1:0];
				end else if (index_q == 2'd1) begin
					pend_d   = pend_q | data_byte[PendingW-1:0];
					pvalid_d = 1'b1;
				end
				if (index_q != 2'd2) begin
					index_d = index_q + 2'd1;
				end
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					finish = 1'b1;
				end
			end
			PH_STOPPED: begin
			end
			default: begin
				phase_d = PH_LENGTH;
			end
		endcase
		if (finish) begin
			phase_d = PH_LENGTH;
		end
	end

	// Commit the record flags when a qualifying record closes
	always_comb begin
		commit_d = commit_q;
		if (finish && is_phy_d && pvalid_d) begin
			commit_d.found    = 1'b1;
			commit_d.phy_1m   = commit_q.phy_1m | pend_d[Flag1mBit];
			commit_d.phy_2m   = commit_q.phy_2m | pend_d[Flag2mBit];
			commit_d.coded    = commit_q.coded | pend_d[FlagCodedS2Bit]
			                    | pend_d[FlagCodedS8Bit];
			commit_d.coded_s8 = commit_q.coded_s8 | pend_d[FlagCodedS8Bit];
		end
	end

	assign flags = commit_d;

	// Hold state; clear everything after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			left_q   <= '0;
			index_q  <= '0;
			is_phy_q <= 1'b0;
			pend_q   <= '0;
			pvalid_q <= 1'b0;
			commit_q <= '0;
		end else if (step_en) begin
			if (is_last) begin
				phase_q  <= PH_LENGTH;
				left_q   <= '0;
				index_q  <= '0;
				is_phy_q <= 1'b0;
				pend_q   <= '0;
				pvalid_q <= 1'b0;
				commit_q <= '0;
			end else begin
				phase_q  <= phase_d;
				left_q   <= left_d;
				index_q  <= index_d;
				is_phy_q <= is_phy_d;
				pend_q   <= pend_d;
				pvalid_q <= pvalid_d;
				commit_q <= commit_d;
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_adv_record_phy_flag_parser_top.sv]
`timescale 1ns / 1ps

module tb_adv_record_phy_flag_parser_top;
	import arpfp_pkg::*;

	localparam int unsigned TargetBytes = 1500;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned MaxReported = 10;

	// Tracks the record walk of each buffer and holds the summaries still due
	class adv_phy_tracker;
		phase_t      walk;
		logic [7:0]  remaining;
		logic [7:0]  pay_idx;
		logic        is_phy;
		logic [7:0]  pend;
		logic        pend_ok;
		phy_flags_t  committed;
		phy_flags_t  summary_queue[$];
		int unsigned mismatches;
		int unsigned summaries_checked;
		int unsigned summaries_found;

		function new();
			mismatches        = 0;
			summaries_checked = 0;
			summaries_found   = 0;
			clear_walk();
		endfunction

		function void clear_walk();
			walk      = PH_LENGTH;
			remaining = 8'd0;
			pay_idx   = 8'd0;
			is_phy    = 1'b0;
			pend      = 8'd0;
			pend_ok   = 1'b0;
			committed = '0;
		endfunction

		// Fold a finished record into the sticky flags if it qualifies
		function void close_record();
			if (is_phy && pend_ok) begin
				committed.found = 1'b1;
				if (pend[Flag1mBit])
					committed.phy_1m = 1'b1;
				if (pend[Flag2mBit])
					committed.phy_2m = 1'b1;
				if (pend[FlagCodedS2Bit] || pend[FlagCodedS8Bit])
					committed.coded = 1'b1;
				if (pend[FlagCodedS8Bit])
					committed.coded_s8 = 1'b1;
			end
			walk = PH_LENGTH;
		endfunction

		// Advance the walk on one accepted byte; queue a summary on the last one
		function void note_byte(logic [7:0] b, logic last);
			case (walk)
				PH_LENGTH: begin
					if (b == 8'd0) begin
						walk = PH_STOPPED;
					end else begin
						remaining = b;
						walk      = PH_TYPE;
					end
				end
				PH_TYPE: begin
					is_phy    = (b == PhyRecordType);
					pay_idx   = 8'd0;
					pend      = 8'd0;
					pend_ok   = 1'b0;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						close_record();
					else
						walk = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (pay_idx == 8'd0) begin
						pend = b;
					end else if (pay_idx == 8'd1) begin
						pend    = pend | b;
						pend_ok = 1'b1;
					end
					if (pay_idx != 8'hFF)
						pay_idx = pay_idx + 8'd1;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						close_record();
				end
				default: begin
				end
			endcase
			if (last) begin
				summary_queue.push_back(committed);
				clear_walk();
			end
		endfunction

		// Compare one delivered summary with the oldest one due
		function void check_summary(logic [7:0] got);
			phy_flags_t act;
			phy_flags_t exp_flags;
			act = got[4:0];
			if (summary_queue.size() == 0) begin
				if (mismatches < MaxReported)
					$display("unexpected summary: tdata=%02h", got);
				mismatches++;
			end else begin
				exp_flags = summary_queue.pop_front();
				summaries_checked++;
				if (exp_flags.found)
					summaries_found++;
				if (act !== exp_flags || got[7:5] !== 3'b000) begin
					if (mismatches < MaxReported)
						$display({"summary mismatch: found %b/%b 1m %b/%b 2m %b/%b ",
							"coded %b/%b s8 %b/%b pad %b (expected/actual)"},
							exp_flags.found, act.found, exp_flags.phy_1m, act.phy_1m,
							exp_flags.phy_2m, act.phy_2m, exp_flags.coded, act.coded,
							exp_flags.coded_s8, act.coded_s8, got[7:5]);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	adv_phy_tracker tracker;
	logic [7:0]     frame_bytes[$];
	int unsigned    cycle_count;
	int unsigned    bytes_sent;
	int unsigned    frames_sent;
	int             stall_left;
	logic           tx_no_idle;
	logic           rx_no_idle;

	adv_record_phy_flag_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check delivered summaries and stall the master side at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_summary(m_tdata);
		if (cycle_count % 256 == 0)
			rx_no_idle = ($urandom_range(0, 3) == 0);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!rx_no_idle && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one byte, hold it until accepted, then record it
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		tracker.note_byte(b, last);
		bytes_sent++;
	endtask

	// Send the staged buffer with tlast on its final byte
	task automatic send_frame();
		tx_no_idle = ($urandom_range(0, 4) == 0);
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
	endtask

	task automatic stage(input logic [7:0] b);
		frame_bytes.push_back(b);
	endtask

	// Append one complete record; type 0x27 about half the time
	task automatic stage_record();
		int len;
		len = ($urandom_range(0, 99) < 2) ? $urandom_range(7, 255) : $urandom_range(1, 6);
		stage(len[7:0]);
		stage($urandom_range(0, 1) ? PhyRecordType : 8'($urandom_range(0, 255)));
		repeat (len - 1) stage(8'($urandom_range(0, 255)));
	endtask

	// Build a random buffer: mostly well-formed records, some noise
	task automatic build_random_frame();
		int kind;
		int len;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			repeat ($urandom_range(1, 5)) stage_record();
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				// Stop the walk, then trailing bytes that must be ignored
				stage(8'd0);
				repeat ($urandom_range(0, 6)) stage(8'($urandom_range(0, 255)));
			end else if (kind < 35) begin
				// Record that runs past the buffer end
				len = $urandom_range(2, 20);
				stage(len[7:0]);
				if ($urandom_range(0, 3) != 0) begin
					stage($urandom_range(0, 1) ? PhyRecordType : 8'($urandom_range(0, 255)));
					repeat ($urandom_range(0, len - 2)) stage(8'($urandom_range(0, 255)));
				end
			end
		end else if (kind < 88) begin
			repeat ($urandom_range(1, 12)) stage(8'($urandom_range(0, 255)));
		end else begin
			stage(8'($urandom_range(0, 255)));
		end
	endtask

	// Directed buffers: extremes and each corner of the walk
	task automatic run_directed();
		// Single-byte buffer, zero length
		frame_bytes = '{8'h00};
		send_frame();
		// Lone nonzero length byte at the end
		frame_bytes = '{8'hFF};
		send_frame();
		// PHY record with 1M and 2M, then a record cut off by the end
		frame_bytes = '{8'h03, 8'h27, 8'h01, 8'h02, 8'h05, 8'h27, 8'h0F};
		send_frame();
		// Type-only record, then a PHY record with coded S8 in tx
		frame_bytes = '{8'h01, 8'h27, 8'h03, 8'h27, 8'h08, 8'h00};
		send_frame();
		// Short PHY record, stop, then ignored bytes
		frame_bytes = '{8'h02, 8'h27, 8'h0F, 8'h00, 8'h03, 8'h27, 8'hFF};
		send_frame();
		// Extra payload after the two flag bytes, coded S2 from rx
		frame_bytes = '{8'h04, 8'h27, 8'hF0, 8'h04, 8'hFF};
		send_frame();
	endtask

	initial begin
		tracker     = new();
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= 8'd0;
		s_tlast     <= 1'b0;
		m_tready    <= 1'b0;
		cycle_count = 0;
		bytes_sent  = 0;
		frames_sent = 0;
		stall_left  = 0;
		tx_no_idle  = 1'b0;
		rx_no_idle  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		while (bytes_sent < TargetBytes) begin
			build_random_frame();
			send_frame();
		end
		s_tvalid <= 1'b0;

		// Drain outstanding summaries, then allow for the pipeline
		while (tracker.summary_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes in %0d buffers; %0d summaries checked, %0d with a PHY record",
			bytes_sent, frames_sent, tracker.summaries_checked, tracker.summaries_found);
		$display("mismatches: %0d", tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.summary_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/arpfp_pkg.sv
hdl/arpfp_walker.sv
hdl/adv_record_phy_flag_parser_top.sv
tb/sv/tb_adv_record_phy_flag_parser_top.sv
